@@ sv/bdar_pkg.sv @@
// Shared types and constants for the button debounce / auto-repeat core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bdar_pkg;

    localparam int TIME_W          = 64;  // microsecond counter and stamps
    localparam int CFG_W           = 24;  // width of each config register
    localparam int CFG_IDX_W       = 2;
    localparam int BTN_W           = 4;   // button field on both channels
    localparam int MASK_W          = 16;
    localparam int MAX_OUT         = 3;   // events per tick at most
    localparam int CNT_W           = 2;
    localparam int NUM_BUTTONS_DEF = 3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 24'd20000;
    localparam logic [CFG_W-1:0] DELAY_RST    = 24'd500000;
    localparam logic [CFG_W-1:0] INTERVAL_RST = 24'd100000;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_RELEASE = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_REPEAT  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,    // advance time counter
        ST_CMP_PR,  // press stamp <= release stamp
        ST_CMP_RP,  // release stamp <= press stamp
        ST_DEB,     // leading stamp + debounce <= now
        ST_SCHED,   // next repeat = now + delay
        ST_REP,     // next repeat <= now
        ST_ADV,     // next repeat += interval
        ST_FLUSH    // hand over the held-back event as last of the run
    } state_t;

    typedef struct packed {
        logic             op;
        logic [BTN_W-1:0] button;
        logic             rise;
    } in_t;

    typedef struct packed {
        logic [BTN_W-1:0]  button;
        kind_t             kind;
        logic [MASK_W-1:0] mask;
        logic              last;
    } evt_t;

endpackage

`default_nettype wire

@@ sv/bdar_alu.sv @@
// Shared 64-bit adder with a compare of the sum against a third operand.
// Depends on bdar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdar_alu
    import bdar_pkg::*;
(
    input  wire logic [TIME_W-1:0] opa,
    input  wire logic [TIME_W-1:0] opb,
    input  wire logic [TIME_W-1:0] opc,
    output logic      [TIME_W-1:0] sum,
    output logic                   le
);

    assign sum = opa + opb;   // wraps at 64 bits
    assign le  = (sum <= opc);

endmodule

`default_nettype wire

@@ sv/bdar_scan.sv @@
// Sequencer and per-button state: stamps, debounced state, repeat schedule.
// Steps one shared bdar_alu over the buttons on each tick. Depends on bdar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdar_scan
    import bdar_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_accept,
    input  wire in_t              in_item,
    input  wire logic [CFG_W-1:0] debounce_time,
    input  wire logic [CFG_W-1:0] repeat_delay,
    input  wire logic [CFG_W-1:0] repeat_interval,
    input  wire logic             out_free,
    output logic                  idle,
    output logic                  push,
    output evt_t                  push_evt
);

    localparam int BIDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    state_t                  state_reg, state_next;
    logic [BIDX_W-1:0]       btn_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    p_le_r_reg, r_le_p_reg;
    logic [TIME_W-1:0]       time_reg;
    logic [TIME_W-1:0]       press_reg   [NUM_BUTTONS];
    logic [TIME_W-1:0]       release_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]       next_rep_reg[NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]  pressed_reg;
    logic                    pend_valid_reg;
    evt_t                    pend_reg;

    logic [TIME_W-1:0] alu_a, alu_b, alu_c, alu_sum;
    logic              alu_le;

    logic [TIME_W-1:0]      cur_press, cur_rel, cur_next;
    logic                   cur_pr, want, differs, change, last_btn, can_emit;
    logic                   emit, fire, done_btn, step_btn, edge_hit;
    kind_t                  emit_kind;
    logic [NUM_BUTTONS-1:0] pressed_upd;
    logic [CNT_W-1:0]       cnt_fin;
    logic [BIDX_W-1:0]      edge_idx;

    bdar_alu u_alu (
        .opa (alu_a),
        .opb (alu_b),
        .opc (alu_c),
        .sum (alu_sum),
        .le  (alu_le)
    );

    assign cur_press = press_reg[btn_reg];
    assign cur_rel   = release_reg[btn_reg];
    assign cur_next  = next_rep_reg[btn_reg];
    assign cur_pr    = pressed_reg[btn_reg];
    // equal stamps: neither is newer, no change
    assign differs   = !(p_le_r_reg && r_le_p_reg);
    assign want      = !p_le_r_reg;
    assign change    = differs && (want != cur_pr) && alu_le;
    assign last_btn  = (btn_reg == BIDX_W'(NUM_BUTTONS - 1));
    // a new event may only replace the held one if the output register can take it
    assign can_emit  = !pend_valid_reg || out_free;
    assign fire      = emit && can_emit;
    assign cnt_fin   = cnt_reg + CNT_W'(fire);

    assign edge_hit  = ({1'b0, in_item.button} < (BTN_W + 1)'(NUM_BUTTONS));
    assign edge_idx  = in_item.button[BIDX_W-1:0];

    assign idle      = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        alu_a      = time_reg;
        alu_b      = '0;
        alu_c      = time_reg;
        emit       = 1'b0;
        emit_kind  = KIND_REPEAT;
        done_btn   = 1'b0;
        step_btn   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && in_item.op == OP_TICK) begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                alu_b      = TIME_W'(1);
                state_next = ST_CMP_PR;
            end
            ST_CMP_PR: begin
                alu_a      = cur_press;
                alu_c      = cur_rel;
                state_next = ST_CMP_RP;
            end
            ST_CMP_RP: begin
                alu_a      = cur_rel;
                alu_c      = cur_press;
                state_next = ST_DEB;
            end
            ST_DEB: begin
                alu_a = want ? cur_press : cur_rel;
                alu_b = TIME_W'(debounce_time);
                if (change) begin
                    emit      = 1'b1;
                    emit_kind = want ? KIND_PRESS : KIND_RELEASE;
                    if (can_emit) begin
                        if (want) begin
                            state_next = ST_SCHED;
                        end else begin
                            done_btn = 1'b1;
                        end
                    end
                end else if (cur_pr) begin
                    state_next = ST_REP;
                end else begin
                    done_btn = 1'b1;
                end
            end
            ST_SCHED: begin
                alu_b    = TIME_W'(repeat_delay);
                done_btn = 1'b1;
            end
            ST_REP: begin
                alu_a = cur_next;
                if (alu_le) begin
                    state_next = ST_ADV;
                end else begin
                    done_btn = 1'b1;
                end
            end
            ST_ADV: begin
                alu_a    = cur_next;
                alu_b    = TIME_W'(repeat_interval);
                emit     = 1'b1;
                done_btn = can_emit;
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // scan stops at the last button or once the event budget is used up
        if (done_btn) begin
            if (cnt_fin == CNT_W'(MAX_OUT) || last_btn) begin
                state_next = ST_FLUSH;
            end else begin
                state_next = ST_CMP_PR;
                step_btn   = 1'b1;
            end
        end
    end

    always_comb begin
        pressed_upd = pressed_reg;
        if (state_reg == ST_DEB) begin
            pressed_upd[btn_reg] = want;
        end
    end

    // the held event goes out when a newer one replaces it, or at the end of the scan
    assign push = pend_valid_reg &&
                  (fire || (state_reg == ST_FLUSH && out_free));
    always_comb begin
        push_evt      = pend_reg;
        push_evt.last = (state_reg == ST_FLUSH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            btn_reg        <= '0;
            cnt_reg        <= '0;
            time_reg       <= '0;
            pressed_reg    <= '0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                press_reg[i]    <= '0;
                release_reg[i]  <= '0;
                next_rep_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_IDLE && in_accept) begin
                if (in_item.op == OP_EDGE) begin
                    if (edge_hit) begin
                        if (in_item.rise) begin
                            release_reg[edge_idx] <= time_reg;
                        end else begin
                            press_reg[edge_idx] <= time_reg;
                        end
                    end
                end else begin
                    btn_reg <= '0;
                    cnt_reg <= '0;
                end
            end

            if (state_reg == ST_TICK) begin
                time_reg <= alu_sum;
            end
            if (state_reg == ST_CMP_PR) begin
                p_le_r_reg <= alu_le;
            end
            if (state_reg == ST_CMP_RP) begin
                r_le_p_reg <= alu_le;
            end

            if (fire) begin
                cnt_reg        <= cnt_fin;
                pend_valid_reg <= 1'b1;
                pend_reg       <= '{button: BTN_W'(btn_reg), kind: emit_kind,
                                    mask: MASK_W'(pressed_upd), last: 1'b0};
                if (state_reg == ST_DEB) begin
                    pressed_reg <= pressed_upd;
                end
                if (state_reg == ST_ADV) begin
                    next_rep_reg[btn_reg] <= alu_sum;
                end
            end

            if (state_reg == ST_SCHED) begin
                next_rep_reg[btn_reg] <= alu_sum;
            end

            if (step_btn) begin
                btn_reg <= BIDX_W'(btn_reg + 1'b1);
            end

            if (state_reg == ST_FLUSH && out_free) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/button_debounce_auto_repeat_core.sv @@
// Button debouncer with auto-repeat for up to 16 buttons.
//
// Input stream (s_*): each item is either a one-microsecond tick
// (s_tuser = 1) or an edge report (s_tuser = 0) on button s_tdata[3:0],
// rising (release) when s_tdata[4] is set, falling (press) otherwise.
// Edges on buttons at or beyond NUM_BUTTONS are dropped.
// Result stream (m_*): per tick, zero to three events in button order;
// m_tuser is the kind (released / pressed / held repeat), m_tdata carries the
// button and the debounced pressed mask, m_tlast marks the last event of a tick.
// An edge item stamps the button and leaves the scan idle. A tick steps time,
// then per button compares stamps both ways, checks debounce, schedules or checks
// the repeat, as every 64-bit add and compare uses one shared adder/comparator.
// The first event of a tick appears once the next one or the end of the
// scan is known. s_tready is low while a tick is being worked off.
// A stalled receiver holds one event in the output register and one more in
// the scan; a further event halts the scan until the receiver takes one.
// Reset (aresetn low, synchronous) clears time, stamps, states and schedules
// and loads the register defaults; config writes take effect immediately.
// Dependencies: bdar_pkg, bdar_scan, bdar_alu.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_auto_repeat_core
    import bdar_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // config write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [3:0] button, [4] edge_is_rise, zero pad
    input  wire logic                 s_tuser,   // [0] operation
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,   // [3:0] which_button, [19:4] pressed_mask
    output logic [1:0]                m_tuser,   // [1:0] event_kind
    output logic                      m_tlast    // last_of_run
);

    logic [CFG_W-1:0] debounce_reg, delay_reg, interval_reg;
    logic             m_valid_reg;
    evt_t             m_evt_reg;

    logic             scan_idle, push, out_free, in_accept;
    evt_t             push_evt;
    in_t              in_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RST;
            delay_reg    <= DELAY_RST;
            interval_reg <= INTERVAL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEBOUNCE: debounce_reg <= cfg_wdata;
                REG_DELAY:    delay_reg    <= cfg_wdata;
                REG_INTERVAL: interval_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign s_tready  = scan_idle;
    assign in_accept = s_tvalid && scan_idle;
    assign in_item   = '{op: s_tuser, button: s_tdata[3:0], rise: s_tdata[4]};

    assign out_free  = !m_valid_reg || m_tready;

    bdar_scan #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_scan (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (in_accept),
        .in_item         (in_item),
        .debounce_time   (debounce_reg),
        .repeat_delay    (delay_reg),
        .repeat_interval (interval_reg),
        .out_free        (out_free),
        .idle            (scan_idle),
        .push            (push),
        .push_evt        (push_evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_evt_reg <= push_evt;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_evt_reg.mask, m_evt_reg.button};
    assign m_tuser  = m_evt_reg.kind;
    assign m_tlast  = m_evt_reg.last;

endmodule

`default_nettype wire

@@ sv/bdar_chk.sv @@
// Port-level checks for button_debounce_auto_repeat_core, bound to the top level.
// Depends on bdar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdar_chk
    import bdar_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    logic own_bit;
    assign own_bit = |((m_tdata[19:4] >> m_tdata[3:0]) & 16'd1);

    // result register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // a tick keeps the input side busy for the scan
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_TICK |=> !s_tready)
        else $error("input ready right after a tick");

    // press and repeat show the button as pressed, release as released
    a_mask_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_PRESS || m_tuser == KIND_REPEAT) |-> own_bit)
        else $error("press or repeat with button not in mask");

    a_mask_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_RELEASE |-> !own_bit)
        else $error("release with button still in mask");

endmodule

bind button_debounce_auto_repeat_core bdar_chk u_bdar_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/tb_button_debounce_auto_repeat_core.sv @@
// Self-checking testbench for button_debounce_auto_repeat_core: directed and random
// edge/tick items against a built-in model of the debounce and repeat logic.
// Depends on bdar_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_button_debounce_auto_repeat_core;
    import bdar_pkg::*;

    localparam int NB          = NUM_BUTTONS_DEF;
    localparam int SETTLE      = 40;       // longer than one tick scan
    localparam int CYCLE_LIMIT = 500000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 70;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [3:0] button, [4] edge_is_rise, zero pad
    logic                 s_tuser;   // [0] operation
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // [3:0] which_button, [19:4] pressed_mask
    logic [1:0]           m_tuser;   // [1:0] event_kind
    logic                 m_tlast;

    button_debounce_auto_repeat_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // debounce state as the block should hold it
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] rel_at  [NB];
    logic [TIME_W-1:0] prs_at  [NB];
    logic [TIME_W-1:0] rep_due [NB];
    logic [MASK_W-1:0] held_mask;
    logic [CFG_W-1:0]  deb_us, dly_us, ivl_us;

    evt_t pending_events[$];

    bit          idle_on;
    int unsigned err_cnt, n_items, n_ticks, n_events, n_settings;
    int unsigned cycles;

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 15) : 0;
    endfunction

    function automatic void stamp_edge(logic [BTN_W-1:0] btn, logic rise);
        if (btn < NB) begin
            if (rise)
                rel_at[btn] = now_us;
            else
                prs_at[btn] = now_us;
        end
    endfunction

    // advance time, scan buttons in order, queue up to MAX_OUT events
    function automatic void scan_tick();
        evt_t              ev[MAX_OUT];
        int                n;
        logic              chg, want;
        logic [TIME_W-1:0] lead;
        n = 0;
        now_us = now_us + 64'd1;
        for (int i = 0; i < NB && n < MAX_OUT; i++) begin
            chg = 1'b0;
            if (prs_at[i] != rel_at[i]) begin
                want = prs_at[i] > rel_at[i];
                lead = want ? prs_at[i] : rel_at[i];
                if (want != held_mask[i] && lead + deb_us <= now_us) begin
                    held_mask[i] = want;
                    if (want)
                        rep_due[i] = now_us + dly_us;
                    ev[n].button = BTN_W'(i);
                    ev[n].kind   = want ? KIND_PRESS : KIND_RELEASE;
                    ev[n].mask   = held_mask;
                    ev[n].last   = 1'b0;
                    n++;
                    chg = 1'b1;
                end
            end
            if (!chg && held_mask[i] && rep_due[i] <= now_us) begin
                rep_due[i]   = rep_due[i] + ivl_us;
                ev[n].button = BTN_W'(i);
                ev[n].kind   = KIND_REPEAT;
                ev[n].mask   = held_mask;
                ev[n].last   = 1'b0;
                n++;
            end
        end
        if (n > 0)
            ev[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            pending_events.push_back(ev[k]);
    endfunction

    // valid stays up across back-to-back items; it only drops for a gap
    task automatic send_item(logic op, logic [BTN_W-1:0] btn, logic rise);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, rise, btn};
        do @(posedge aclk); while (!s_tready);
        n_items++;
        if (op == OP_TICK) begin
            n_ticks++;
            scan_tick();
        end else begin
            stamp_edge(btn, rise);
        end
    endtask

    task automatic tick();
        send_item(OP_TICK, BTN_W'($urandom_range(0, 15)), 1'($urandom));
    endtask

    // stop input, let every expected event arrive and the scan finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_regs(logic [CFG_W-1:0] db, logic [CFG_W-1:0] dl, logic [CFG_W-1:0] iv);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_DEBOUNCE;
        cfg_wdata <= db;
        @(posedge aclk);
        deb_us = db;
        cfg_addr  <= REG_DELAY;
        cfg_wdata <= dl;
        @(posedge aclk);
        dly_us = dl;
        cfg_addr  <= REG_INTERVAL;
        cfg_wdata <= iv;
        @(posedge aclk);
        ivl_us = iv;
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic report(string fld, int unsigned exp_v, int unsigned act_v);
        err_cnt++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, exp_v, act_v);
    endtask

    // result sink: random stall between items, checks each accepted item
    initial begin : result_sink
        evt_t want_e;
        int   stall;
        m_tready <= 1'b0;
        stall = draw_gap();
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                n_events++;
                if (pending_events.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected item, button %0d kind %0d mask %h",
                             $time, m_tdata[3:0], m_tuser, m_tdata[19:4]);
                end else begin
                    want_e = pending_events.pop_front();
                    if (m_tdata[3:0] !== want_e.button)
                        report("which_button", want_e.button, m_tdata[3:0]);
                    if (m_tuser !== want_e.kind)
                        report("event_kind", want_e.kind, m_tuser);
                    if (m_tdata[19:4] !== want_e.mask)
                        report("pressed_mask", want_e.mask, m_tdata[19:4]);
                    if (m_tlast !== want_e.last)
                        report("last_of_run", want_e.last, m_tlast);
                end
                stall = draw_gap();
            end else if (stall > 0) begin
                stall--;
            end
            m_tready <= (stall == 0);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events still expected",
                     cycles, pending_events.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // defaults are far too long to fire here; equal stamps at time zero
    task automatic test_reset_defaults();
        send_item(OP_EDGE, 4'd0, 1'b0);
        tick();
        send_item(OP_EDGE, 4'd0, 1'b0);
        send_item(OP_EDGE, 4'd15, 1'b1);
        tick();
    endtask

    // zero debounce/delay/interval: full three-event ticks, repeat every tick
    task automatic test_zero_timing();
        set_regs('0, '0, '0);
        send_item(OP_EDGE, 4'd0, 1'b0);
        send_item(OP_EDGE, 4'd1, 1'b0);
        send_item(OP_EDGE, 4'd2, 1'b0);
        tick();                               // three presses
        tick();                               // zero delay repeats come one tick later
        send_item(OP_EDGE, 4'd3, 1'b0);       // out of range, dropped
        send_item(OP_EDGE, 4'd0, 1'b1);
        send_item(OP_EDGE, 4'd0, 1'b0);       // same stamp both ways: no change
        tick();
        send_item(OP_EDGE, 4'd1, 1'b1);
        tick();                               // release mixed with repeats
        send_item(OP_EDGE, 4'd0, 1'b1);
        send_item(OP_EDGE, 4'd2, 1'b1);
        tick();
    endtask

    task automatic test_register_limits();
        set_regs('1, '1, '1);
        send_item(OP_EDGE, 4'd1, 1'b0);
        tick();
        tick();
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] db, dl, iv;
        int               r;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin db = 1; dl = 3;  iv = 1; end
                1: begin db = 0; dl = 0;  iv = 2; end
                2: begin db = 3; dl = 8;  iv = 4; end
                3: begin db = 2; dl = 0;  iv = 0; end
                default: begin
                    db = CFG_W'($urandom_range(0, 6));
                    dl = CFG_W'($urandom_range(0, 12));
                    iv = CFG_W'($urandom_range(0, 6));
                end
            endcase
            set_regs(db, dl, iv);
            idle_on = (p % 3) != 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    tick();
                else if (r < 93)
                    send_item(OP_EDGE, BTN_W'($urandom_range(0, NB - 1)), 1'($urandom));
                else
                    send_item(OP_EDGE, BTN_W'($urandom_range(NB, 15)), 1'($urandom));
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_DEBOUNCE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_EDGE;
        err_cnt   = 0;
        n_items   = 0;
        n_ticks   = 0;
        n_events  = 0;
        n_settings = 0;
        idle_on   = 1'b1;
        now_us    = '0;
        held_mask = '0;
        deb_us    = DEBOUNCE_RST;
        dly_us    = DELAY_RST;
        ivl_us    = INTERVAL_RST;
        for (int i = 0; i < NB; i++) begin
            rel_at[i]  = '0;
            prs_at[i]  = '0;
            rep_due[i] = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_zero_timing();
        test_register_limits();
        test_random_phases();
        drain();

        $display("ran %0d items (%0d ticks) over %0d register settings",
                 n_items, n_ticks, n_settings);
        $display("checked %0d events, %0d mismatches", n_events, err_cnt);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
